[rtl/atmf_pkg.sv]
package atmf_pkg;

   // Defaults for the top-level parameters
   localparam int KEPT_LEN_DEF  = 8;
   localparam int OUT_SHIFT_DEF = 6;

   // Fixed field widths
   localparam int SAMPLE_W = 16;
   localparam int AXIS_W   = 10;
   localparam int PACKED_W = 3 * AXIS_W;

   // Largest magnitude of one sign-magnitude axis code
   localparam int MAG_LIM = (1 << (AXIS_W - 1)) - 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PREP,
      ST_DIV,
      ST_FIN
   } atmf_state_type;

   // Sequencer strobes shared by all lanes
   typedef struct packed {
      logic load;
      logic primed;
      logic scan;
      logic scan_first;
      logic prep;
      logic div;
   } atmf_lane_ctrl_type;

endpackage

[rtl/atmf_lane.sv]
module atmf_lane
   import atmf_pkg::*;
#(
   parameter int KEPT_LEN  = KEPT_LEN_DEF,
   parameter int OUT_SHIFT = OUT_SHIFT_DEF
) (
   input  logic                       clock,
   input  atmf_lane_ctrl_type         ctrl,
   input  logic signed [SAMPLE_W-1:0] sample,
   output logic [AXIS_W-1:0]          axis_code
);

   localparam int WIN_LEN = KEPT_LEN + 2;
   localparam int SUM_W   = SAMPLE_W + 1 + $clog2(WIN_LEN);
   localparam int MAG_W   = SAMPLE_W + $clog2(WIN_LEN);
   localparam int DIV_L   = $clog2(KEPT_LEN);
   localparam int DIV_SH  = MAG_W + DIV_L;
   localparam int RCP_W   = MAG_W + 1;
   localparam int PROD_W  = MAG_W + RCP_W;
   // ceil(2^DIV_SH / KEPT_LEN): exact truncating quotient for any MAG_W-bit input
   localparam longint RCP_L =
      ((longint'(1) << DIV_SH) + longint'(KEPT_LEN) - longint'(1)) / longint'(KEPT_LEN);
   localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_L);

   logic signed [SAMPLE_W-1:0] win_ff [WIN_LEN];
   logic signed [SAMPLE_W-1:0] win_in [WIN_LEN];
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [SAMPLE_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic                       neg_ff, neg_in;
   logic [MAG_W-1:0]           quot_ff, quot_in;

   logic signed [SAMPLE_W-1:0] tap;
   logic signed [SUM_W-1:0]    trim;
   logic signed [SUM_W-1:0]    trim_abs;
   logic [PROD_W-1:0]          prod;
   logic                       neg_res;
   logic [MAG_W:0]             pos_mag, neg_mag, mag;
   logic [AXIS_W-2:0]          mag_sat;

   assign tap = win_ff[0];

   // Window: fill on first item, shift on later ones, rotate while scanning
   always_comb begin
      win_in = win_ff;
      if (ctrl.load) begin
         for (int i = 0; i < WIN_LEN - 1; i++) begin
            win_in[i] = ctrl.primed ? win_ff[i+1] : sample;
         end
         win_in[WIN_LEN-1] = sample;
      end else if (ctrl.scan) begin
         for (int i = 0; i < WIN_LEN - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[WIN_LEN-1] = win_ff[0];
      end
   end

   // Running sum, min and max over the rotating tap
   always_comb begin
      sum_in = sum_ff;
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      if (ctrl.scan) begin
         if (ctrl.scan_first) begin
            sum_in = SUM_W'(tap);
            lo_in  = tap;
            hi_in  = tap;
         end else begin
            sum_in = sum_ff + SUM_W'(tap);
            if (tap < lo_ff) begin
               lo_in = tap;
            end
            if (tap > hi_ff) begin
               hi_in = tap;
            end
         end
      end
   end

   assign trim     = sum_ff - SUM_W'(lo_ff) - SUM_W'(hi_ff);
   assign trim_abs = trim[SUM_W-1] ? -trim : trim;
   assign prod     = PROD_W'(quot_ff) * PROD_W'(RCP);

   // Magnitude is registered first, then divided by a reciprocal multiply
   always_comb begin
      neg_in  = neg_ff;
      quot_in = quot_ff;
      if (ctrl.prep) begin
         neg_in  = trim[SUM_W-1];
         quot_in = trim_abs[MAG_W-1:0];
      end else if (ctrl.div) begin
         quot_in = MAG_W'(prod >> DIV_SH);
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      sum_ff  <= sum_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   // Floor shift: negative q gives -(((|q|-1) >> s) + 1)
   assign neg_res = neg_ff && (quot_ff != '0);
   assign pos_mag = {1'b0, quot_ff} >> OUT_SHIFT;
   assign neg_mag = (({1'b0, quot_ff} - (MAG_W+1)'(1)) >> OUT_SHIFT) + (MAG_W+1)'(1);
   assign mag     = neg_res ? neg_mag : pos_mag;
   assign mag_sat = (mag > (MAG_W+1)'(MAG_LIM)) ? (AXIS_W-1)'(MAG_LIM) : mag[AXIS_W-2:0];

   assign axis_code = {neg_res, mag_sat};

endmodule

[rtl/atmf_merge.sv]
module atmf_merge
   import atmf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic [AXIS_W-1:0]   x_code,
   input  logic [AXIS_W-1:0]   y_code,
   input  logic [AXIS_W-1:0]   z_code,
   output logic                free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [PACKED_W-1:0] rsp_packed_axes
);

   logic                valid_ff, valid_in;
   logic [PACKED_W-1:0] packed_ff, packed_in;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in  = valid_ff;
      packed_in = packed_ff;
      if (load) begin
         valid_in  = 1'b1;
         packed_in = {x_code, y_code, z_code};
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      packed_ff <= packed_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_packed_axes = packed_ff;

endmodule

[rtl/accel_trimmed_mean_filter.sv]
// Three-axis trimmed-mean filter. Each item carries one signed 16-bit sample
// per axis; the first item after reset fills each axis window (KEPT_LEN+2
// entries), later items shift in and drop the oldest entry. Three lanes, one
// per axis, run in lockstep: a scan rotates the window past one tap to build
// sum, minimum and maximum, the PREP state trims and takes the magnitude,
// then the DIV state divides it by KEPT_LEN with a reciprocal multiply
// (exact, truncating). The quotient is floor-shifted by OUT_SHIFT, saturated
// to a 10-bit sign-magnitude code and the three codes are packed x high into
// the output register. The next item is accepted only once the scan, trim,
// divide and hand-off to the output register are done; the hand-off waits
// while the output register holds a result not yet taken. The output register
// lets the next item enter while the last result is still waiting to be
// taken. Reset is synchronous and clears control state only.
module accel_trimmed_mean_filter
   import atmf_pkg::*;
#(
   parameter int KEPT_LEN  = KEPT_LEN_DEF,
   parameter int OUT_SHIFT = OUT_SHIFT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_x_sample,
   input  logic signed [SAMPLE_W-1:0] req_y_sample,
   input  logic signed [SAMPLE_W-1:0] req_z_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [PACKED_W-1:0]        rsp_packed_axes
);

   localparam int WIN_LEN = KEPT_LEN + 2;
   localparam int CNT_W   = $clog2(WIN_LEN);

   atmf_state_type     state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               primed_ff, primed_in;
   atmf_lane_ctrl_type lane_ctrl;
   logic               merge_load;
   logic               merge_free;
   logic [AXIS_W-1:0]  x_code, y_code, z_code;
   logic               scan_last;

   assign scan_last = (cnt_ff == CNT_W'(WIN_LEN - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: state_in = ST_DIV;
         ST_DIV:  state_in = ST_FIN;
         ST_FIN: begin
            if (merge_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Step counter for the scan
   always_comb begin
      cnt_in = '0;
      if (state_ff == ST_SCAN && !scan_last) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   // Outputs of the sequencer
   always_comb begin
      req_ready             = 1'b0;
      merge_load            = 1'b0;
      lane_ctrl             = '0;
      lane_ctrl.primed      = primed_ff;
      lane_ctrl.scan_first  = (cnt_ff == '0);
      primed_in             = primed_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            lane_ctrl.load = req_valid;
            if (req_valid) begin
               primed_in = 1'b1;
            end
         end
         ST_SCAN: lane_ctrl.scan = 1'b1;
         ST_PREP: lane_ctrl.prep = 1'b1;
         ST_DIV:  lane_ctrl.div  = 1'b1;
         ST_FIN:  merge_load     = merge_free;
         default: req_ready      = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         primed_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         primed_ff <= primed_in;
      end
   end

   atmf_lane #(
      .KEPT_LEN  (KEPT_LEN),
      .OUT_SHIFT (OUT_SHIFT)
   ) u_lane_x (
      .clock     (clock),
      .ctrl      (lane_ctrl),
      .sample    (req_x_sample),
      .axis_code (x_code)
   );

   atmf_lane #(
      .KEPT_LEN  (KEPT_LEN),
      .OUT_SHIFT (OUT_SHIFT)
   ) u_lane_y (
      .clock     (clock),
      .ctrl      (lane_ctrl),
      .sample    (req_y_sample),
      .axis_code (y_code)
   );

   atmf_lane #(
      .KEPT_LEN  (KEPT_LEN),
      .OUT_SHIFT (OUT_SHIFT)
   ) u_lane_z (
      .clock     (clock),
      .ctrl      (lane_ctrl),
      .sample    (req_z_sample),
      .axis_code (z_code)
   );

   // Packs the three codes and holds the item until taken
   atmf_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .load            (merge_load),
      .x_code          (x_code),
      .y_code          (y_code),
      .z_code          (z_code),
      .free            (merge_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_packed_axes (rsp_packed_axes)
   );

endmodule

[rtl/atmf_checker.sv]
module atmf_checker
   import atmf_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [PACKED_W-1:0] rsp_packed_axes
);

   // No item shows right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item valid after reset");

   // A stalled item holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_packed_axes))
      else $error("result item dropped or changed while stalled");

   // One item at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again right after an accept");

   // No axis is coded as negative zero
   a_no_neg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_packed_axes[29] && rsp_packed_axes[28:20] == 9'd0) &&
                    !(rsp_packed_axes[19] && rsp_packed_axes[18:10] == 9'd0) &&
                    !(rsp_packed_axes[9]  && rsp_packed_axes[8:0]   == 9'd0))
      else $error("axis coded as negative zero");

endmodule

bind accel_trimmed_mean_filter atmf_checker u_atmf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_packed_axes (rsp_packed_axes)
);
